// ===== sv/gcrf_pkg.sv =====
package gcrf_pkg;

  // field widths
  localparam int ID_W   = 16;
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 19;
  localparam int CFG_W  = 25;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 40;

  // datapath widths
  localparam int MAG_W   = 26;
  localparam int ANG_W   = 32;
  localparam int CW      = 34;
  localparam int SQ_BITS = 31;
  localparam int RAD_W   = 2 * SQ_BITS;
  localparam int REM_W   = 34;

  // default rotation count of both cordic units
  localparam int CORDIC_STEPS_DEF = 20;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // register indexes
  localparam logic [1:0] CFG_REF_LAT  = 2'd0;
  localparam logic [1:0] CFG_REF_LON  = 2'd1;
  localparam logic [1:0] CFG_MAX_DIST = 2'd2;

  localparam logic [DIST_W-1:0] MAX_DIST_RST = 19'd16000;

  // floor(2^38 / 45), reciprocal for the degree to binary-angle scaling
  localparam logic [32:0] RECIP_45    = 33'd6108397932;
  localparam int          RECIP_SHIFT = 38;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;

  // binary angle to 1/16 km, rounded
  localparam logic [31:0] DIST_MUL   = 32'd2623417457;
  localparam int          DIST_SHIFT = 43;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [3:0]            neg;
    logic [3:0][MAG_W-1:0] mag;
  } item_t;

  // atan(2^-i) in binary-angle units
  function automatic logic [31:0] atan_units(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/great_circle_radius_filter.sv =====
// Great-circle radius filter: haversine distance of each point from a
// reference point, with a flag for points inside a configured radius.
// Input channel in_*: one request per point, in_tdata carries point_id,
// latitude and longitude (degrees times 65536, two's complement).
// Output channel out_*: exactly one request per input, in order, with the
// id, the distance in 1/16 km (saturated) and the within-limit flag.
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 reference latitude, 1 reference longitude, 2 limit); write only
// while no point is in flight.
// Throughput: one point per cycle while the back pipeline is not held by
// out_tready. The path from accept to out_tvalid runs through the two
// cordic pipelines and the 31-stage square-root pipelines.
// Reset (rst_n low, synchronous) empties the queue and the pipeline and
// loads the reference point 0,0 and a limit of 16000 (1000 km).
// With out_tvalid high and out_tready low the whole back pipeline holds;
// the four-entry queue keeps taking points until it fills, then in_tready drops.
module great_circle_radius_filter #(
  parameter int CORDIC_STEPS = gcrf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // point_id[15:0], latitude[39:16], longitude[64:40], zero fill
  input  logic [gcrf_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // result_id[15:0], distance[34:16], within_limit[35], zero fill
  output logic [gcrf_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [gcrf_pkg::CFG_W-1:0]    cfg_wdata
);

  logic signed [gcrf_pkg::LAT_W-1:0] ref_lat_r;
  logic signed [gcrf_pkg::LON_W-1:0] ref_lon_r;
  logic [gcrf_pkg::DIST_W-1:0]       max_dist_r;
  logic                              q_full, q_push, q_pop, q_valid;
  gcrf_pkg::item_t                   q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lat_r  <= '0;
      ref_lon_r  <= '0;
      max_dist_r <= gcrf_pkg::MAX_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcrf_pkg::CFG_REF_LAT:  ref_lat_r  <= cfg_wdata[gcrf_pkg::LAT_W-1:0];
        gcrf_pkg::CFG_REF_LON:  ref_lon_r  <= cfg_wdata[gcrf_pkg::LON_W-1:0];
        gcrf_pkg::CFG_MAX_DIST: max_dist_r <= cfg_wdata[gcrf_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  gcrf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ref_lat   (ref_lat_r),
    .ref_lon   (ref_lon_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wdata)
  );

  gcrf_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  gcrf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_rdata),
    .head_valid   (q_valid),
    .pop          (q_pop),
    .dist_limit   (max_dist_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== sv/gcrf_front.sv =====
module gcrf_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gcrf_pkg::IN_W-1:0]           in_tdata,
  input  logic signed [gcrf_pkg::LAT_W-1:0]   ref_lat,
  input  logic signed [gcrf_pkg::LON_W-1:0]   ref_lon,
  input  logic                                q_full,
  output logic                                q_push,
  output gcrf_pkg::item_t                     q_item
);

  logic signed [gcrf_pkg::LAT_W-1:0] lat_w;
  logic signed [gcrf_pkg::LON_W-1:0] lon_w;
  logic signed [26:0]                v [4];

  assign lat_w = in_tdata[39:16];
  assign lon_w = in_tdata[64:40];

  // request taken whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // lanes: lat delta, lon delta, reference lat, point lat
  always_comb begin
    v[0] = 27'(lat_w) - 27'(ref_lat);
    v[1] = 27'(lon_w) - 27'(ref_lon);
    v[2] = 27'(ref_lat);
    v[3] = 27'(lat_w);
    q_item.id = in_tdata[15:0];
    for (int j = 0; j < 4; j++) begin
      q_item.neg[j] = v[j][26];
      q_item.mag[j] = v[j][26] ? 26'(-v[j]) : 26'(v[j]);
    end
  end

endmodule

// ===== sv/gcrf_fifo.sv =====
module gcrf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gcrf_pkg::item_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            rvalid,
  output gcrf_pkg::item_t rdata
);

  gcrf_pkg::item_t                  mem [gcrf_pkg::QUEUE_DEPTH];
  logic [gcrf_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [gcrf_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [gcrf_pkg::QPTR_W:0]        cnt_r, cnt_nxt;

  assign full   = (cnt_r == (gcrf_pkg::QPTR_W + 1)'(gcrf_pkg::QUEUE_DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (gcrf_pkg::QPTR_W + 1)'(push) - (gcrf_pkg::QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/gcrf_rot.sv =====
module gcrf_rot #(
  parameter int STEPS = gcrf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             use_cos,
  input  logic [gcrf_pkg::ANG_W-1:0]       ang,
  output logic signed [gcrf_pkg::CW-1:0]   res
);

  logic signed [gcrf_pkg::CW-1:0] x_r [STEPS+1];
  logic signed [gcrf_pkg::CW-1:0] y_r [STEPS+1];
  logic signed [gcrf_pkg::CW-1:0] z_r [STEPS];
  logic                           neg_r [STEPS+1];
  logic signed [gcrf_pkg::CW-1:0] z0, zf;
  logic                           nf;

  // fold into the right half plane
  always_comb begin
    z0 = gcrf_pkg::CW'(signed'(ang));
    zf = z0;
    nf = 1'b0;
    if (z0 > gcrf_pkg::Q30_ONE) begin
      zf = z0 - (gcrf_pkg::Q30_ONE <<< 1);
      nf = 1'b1;
    end else if (z0 < -gcrf_pkg::Q30_ONE) begin
      zf = z0 + (gcrf_pkg::Q30_ONE <<< 1);
      nf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= gcrf_pkg::CORDIC_GAIN;
      y_r[0]   <= '0;
      z_r[0]   <= zf;
      neg_r[0] <= nf;
    end
  end

  // one rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [gcrf_pkg::CW-1:0] AT = gcrf_pkg::CW'(gcrf_pkg::atan_units(i));
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][gcrf_pkg::CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
      end
    end
    if (i < STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i+1] <= z_r[i][gcrf_pkg::CW-1] ? z_r[i] + AT : z_r[i] - AT;
        end
      end
    end
  end

  // undo the fold, pick sine or cosine
  always_ff @(posedge clk) begin
    if (en) begin
      if (use_cos) begin
        res <= neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
      end else begin
        res <= neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
      end
    end
  end

endmodule

// ===== sv/gcrf_sqrt.sv =====
module gcrf_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gcrf_pkg::RAD_W-1:0]    rad,
  output logic [gcrf_pkg::SQ_BITS-1:0]  root
);

  localparam int N = gcrf_pkg::SQ_BITS;

  logic [gcrf_pkg::REM_W-1:0] rem_r  [N];
  logic [N-1:0]               root_r [N];
  logic [gcrf_pkg::RAD_W-1:0] rad_r  [N-1];

  // one root bit per stage, restoring form
  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [gcrf_pkg::REM_W-1:0] rem_in, cur, trial;
    logic [N-1:0]               root_in;
    logic [gcrf_pkg::RAD_W-1:0] rad_in;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end
    assign cur   = {rem_in[gcrf_pkg::REM_W-3:0], rad_in[gcrf_pkg::RAD_W-1 -: 2]};
    assign trial = gcrf_pkg::REM_W'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[i]  <= cur - trial;
          root_r[i] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_r[i]  <= cur;
          root_r[i] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
    if (i < N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i] <= rad_in << 2;
        end
      end
    end
  end

  assign root = root_r[N-1];

endmodule

// ===== sv/gcrf_vec.sv =====
module gcrf_vec #(
  parameter int STEPS = gcrf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [gcrf_pkg::SQ_BITS-1:0]       x_in,
  input  logic [gcrf_pkg::SQ_BITS-1:0]       y_in,
  output logic signed [gcrf_pkg::CW-1:0]     z_out
);

  logic signed [gcrf_pkg::CW-1:0] x_r [STEPS];
  logic signed [gcrf_pkg::CW-1:0] y_r [STEPS];
  logic signed [gcrf_pkg::CW-1:0] z_r [STEPS];

  // drive y toward zero, summing the angle
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [gcrf_pkg::CW-1:0] AT = gcrf_pkg::CW'(gcrf_pkg::atan_units(i));
    logic signed [gcrf_pkg::CW-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = signed'(gcrf_pkg::CW'(x_in));
      assign yi = signed'(gcrf_pkg::CW'(y_in));
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + AT;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - AT;
        end
      end
    end
  end

  assign z_out = z_r[STEPS-1];

endmodule

// ===== sv/gcrf_back.sv =====
module gcrf_back #(
  parameter int CORDIC_STEPS = gcrf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcrf_pkg::item_t                   head,
  input  logic                              head_valid,
  output logic                              pop,
  input  logic [gcrf_pkg::DIST_W-1:0]       dist_limit,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gcrf_pkg::OUT_W-1:0]        out_tdata
);

  localparam int LAT = 2 * CORDIC_STEPS + 40;

  logic                              en;
  logic signed [gcrf_pkg::CW-1:0]    rot_res [4];
  logic [LAT-1:0]                    vld_r;
  logic [LAT-1:0][gcrf_pkg::ID_W-1:0] id_r;
  logic                              out_valid_r;
  logic [gcrf_pkg::ID_W-1:0]         out_id_r;
  logic [gcrf_pkg::DIST_W-1:0]       out_dist_r;
  logic                              out_within_r;

  // whole pipeline advances while the output slot is free or taken
  assign en  = !out_valid_r || out_tready;
  assign pop = en && head_valid;

  // angle scaling and sine/cosine per lane
  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int SH = (j < 2) ? 12 : 13;
    logic [58:0] prod_r;
    logic        neg1_r, neg2_r, inc_r;
    logic [32:0] q0_c, q0_r, q_c;
    logic [7:0]  lo45;
    logic [31:0] ang_r;

    assign q0_c = 33'(prod_r >> (gcrf_pkg::RECIP_SHIFT - SH));
    // remainder low byte; the scaled value has zero low byte
    assign lo45 = 8'(16'(q0_c[7:0]) * 16'd45);
    assign q_c  = q0_r + 33'(inc_r);

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r <= 59'(head.mag[j]) * 59'(gcrf_pkg::RECIP_45);
        neg1_r <= head.neg[j];
        q0_r   <= q0_c;
        inc_r  <= (8'(8'd0 - lo45) >= 8'd45);
        neg2_r <= neg1_r;
        ang_r  <= neg2_r ? 32'(-q_c) : 32'(q_c);
      end
    end

    gcrf_rot #(.STEPS(CORDIC_STEPS)) u_rot (
      .clk     (clk),
      .en      (en),
      .use_cos (1'(j >= 2)),
      .ang     (ang_r),
      .res     (rot_res[j])
    );
  end

  // haversine term a, clamped to [0, 1]
  logic signed [67:0]              p_cc, p_ss, p_la, p_t;
  logic signed [gcrf_pkg::CW-1:0]  m_cc_r, m_ss_r, m_la_r, m_t_r, m_la2_r;
  logic signed [gcrf_pkg::CW:0]    a_sum;
  logic [gcrf_pkg::SQ_BITS-1:0]    a_r, b_r, sa, sb;

  assign p_cc  = rot_res[2] * rot_res[3];
  assign p_ss  = rot_res[1] * rot_res[1];
  assign p_la  = rot_res[0] * rot_res[0];
  assign p_t   = m_cc_r * m_ss_r;
  assign a_sum = (gcrf_pkg::CW + 1)'(m_la2_r) + (gcrf_pkg::CW + 1)'(m_t_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_cc_r  <= gcrf_pkg::CW'(p_cc >>> 30);
      m_ss_r  <= gcrf_pkg::CW'(p_ss >>> 30);
      m_la_r  <= gcrf_pkg::CW'(p_la >>> 30);
      m_t_r   <= gcrf_pkg::CW'(p_t >>> 30);
      m_la2_r <= m_la_r;
      if (a_sum[gcrf_pkg::CW]) begin
        a_r <= '0;
        b_r <= 31'h4000_0000;
      end else if (a_sum > (gcrf_pkg::CW + 1)'(gcrf_pkg::Q30_ONE)) begin
        a_r <= 31'h4000_0000;
        b_r <= '0;
      end else begin
        a_r <= a_sum[30:0];
        b_r <= 31'h4000_0000 - a_sum[30:0];
      end
    end
  end

  gcrf_sqrt u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, a_r, 30'd0}),
    .root (sa)
  );

  gcrf_sqrt u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, b_r, 30'd0}),
    .root (sb)
  );

  logic signed [gcrf_pkg::CW-1:0] z_ang;

  gcrf_vec #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk   (clk),
    .en    (en),
    .x_in  (sb),
    .y_in  (sa),
    .z_out (z_ang)
  );

  // angle to distance, product split in two halves
  logic [30:0] zc;
  logic [47:0] p_lo_r;
  logic [46:0] p_hi_r;
  logic [63:0] d_sum;
  logic [20:0] d_full;
  logic [gcrf_pkg::DIST_W-1:0] d_sat;

  assign zc = z_ang[gcrf_pkg::CW-1] ? '0 : z_ang[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= 48'(zc[15:0]) * 48'(gcrf_pkg::DIST_MUL);
      p_hi_r <= 47'(zc[30:16]) * 47'(gcrf_pkg::DIST_MUL);
    end
  end

  always_comb begin
    d_sum  = (64'(p_hi_r) << 16) + 64'(p_lo_r) + (64'd1 << (gcrf_pkg::DIST_SHIFT - 1));
    d_full = d_sum[63:gcrf_pkg::DIST_SHIFT];
    d_sat  = (d_full[20:19] != 2'b00) ? '1 : d_full[18:0];
  end

  // valid and id travel beside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id_r <= {id_r[LAT-2:0], head.id};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_id_r     <= id_r[LAT-1];
      out_dist_r   <= d_sat;
      out_within_r <= (d_sat <= dist_limit);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_within_r, out_dist_r, out_id_r};

endmodule

// ===== tb/tb_great_circle_radius_filter.sv =====
`timescale 1ns / 1ps

module tb_great_circle_radius_filter;

  localparam int  ROT_STEPS   = 20;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = 2 * ROT_STEPS + 60;
  localparam int  HOLD_CYCLES = 300;
  localparam longint unsigned KM16_MUL = 64'd2623417457;
  localparam longint unsigned KM16_MAX = 64'd524287;
  localparam longint HALF_TURN_Q = 64'd1073741824;

  // arctangent of 2^-i in binary-angle units
  localparam longint ATAN_TBL [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304
  };

  typedef struct {
    logic [gcrf_pkg::ID_W-1:0]   id;
    logic [gcrf_pkg::DIST_W-1:0] km16;
    logic                        near;
  } dist_result_t;

  typedef struct {
    logic [gcrf_pkg::ID_W-1:0]         id;
    logic signed [gcrf_pkg::LAT_W-1:0] lat;
    logic signed [gcrf_pkg::LON_W-1:0] lon;
    bit                                typed;
    logic [gcrf_pkg::DIST_W-1:0]       km16;
    logic                              near;
  } point_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [gcrf_pkg::IN_W-1:0]   in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [gcrf_pkg::OUT_W-1:0]  out_tdata;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [gcrf_pkg::CFG_W-1:0]  cfg_wdata;

  great_circle_radius_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // copy of the register file
  logic signed [gcrf_pkg::LAT_W-1:0] ref_lat_q;
  logic signed [gcrf_pkg::LON_W-1:0] ref_lon_q;
  logic [gcrf_pkg::DIST_W-1:0]       limit_q;

  dist_result_t pending_dist_q[$];
  point_row_t   sent_rows_q[$];
  int           n_accepted;
  int           n_sent;
  int           n_errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cnt;
  int           cycle_cnt = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cordic rotation: sine and cosine of a binary angle, Q30
  function automatic void rotate_angle(input logic [31:0] ang,
                                       output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // cordic vectoring: angle of (x, y)
  function automatic longint vector_arg(input longint x0, input longint y0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v0);
    longint unsigned v, r, b;
    v = v0;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // degrees*65536 to binary angle, truncated toward zero
  function automatic logic [31:0] deg_to_bang(input longint v, input longint mul);
    longint q;
    q = (v * mul) / 45;
    return q[31:0];
  endfunction

  // haversine distance in 1/16 km from the reference point
  function automatic logic [gcrf_pkg::DIST_W-1:0] haversine_km16(
      input logic signed [gcrf_pkg::LAT_W-1:0] lat,
      input logic signed [gcrf_pkg::LON_W-1:0] lon);
    longint lat1, lon1, lat2, lon2;
    longint s_dlat, s_dlon, c1, c2, junk, t, a, z;
    longint unsigned sa, sb, d;
    lat1 = longint'(ref_lat_q);
    lon1 = longint'(ref_lon_q);
    lat2 = longint'(lat);
    lon2 = longint'(lon);
    rotate_angle(deg_to_bang(lat2 - lat1, 4096), s_dlat, junk);
    rotate_angle(deg_to_bang(lon2 - lon1, 4096), s_dlon, junk);
    rotate_angle(deg_to_bang(lat1, 8192), junk, c1);
    rotate_angle(deg_to_bang(lat2, 8192), junk, c2);
    t = (c1 * c2) >>> 30;
    t = (t * ((s_dlon * s_dlon) >>> 30)) >>> 30;
    a = ((s_dlat * s_dlat) >>> 30) + t;
    if (a < 0) a = 0;
    if (a > HALF_TURN_Q) a = HALF_TURN_Q;
    sa = floor_sqrt(longint'(a) << 30);
    sb = floor_sqrt(longint'(HALF_TURN_Q - a) << 30);
    z = vector_arg(longint'(sb), longint'(sa));
    if (z < 0) z = 0;
    d = (longint'(z) * KM16_MUL + (64'd1 << 42)) >> 43;
    if (d > KM16_MAX) d = KM16_MAX;
    return d[gcrf_pkg::DIST_W-1:0];
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // predict on each input request, check each output request
  always @(posedge clk) begin
    point_row_t   row;
    dist_result_t res, got;
    if (rst_n && in_tvalid && in_tready) begin
      row = sent_rows_q.pop_front();
      res.id = in_tdata[15:0];
      if (row.typed) begin
        res.km16 = row.km16;
        res.near = row.near;
      end else begin
        res.km16 = haversine_km16(in_tdata[39:16], in_tdata[64:40]);
        res.near = (res.km16 <= limit_q);
      end
      pending_dist_q = {pending_dist_q, res};
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.id   = out_tdata[15:0];
      got.km16 = out_tdata[34:16];
      got.near = out_tdata[35];
      if (pending_dist_q.size() == 0) begin
        $error("unexpected result id %0d", got.id);
        n_errors++;
      end else begin
        res = pending_dist_q.pop_front();
        if (got.id !== res.id) begin
          $error("result_id: expected %0d actual %0d", res.id, got.id);
          n_errors++;
        end
        if (got.km16 !== res.km16) begin
          $error("distance: expected %0d actual %0d", res.km16, got.km16);
          n_errors++;
        end
        if (got.near !== res.near) begin
          $error("within_limit: expected %0d actual %0d", res.near, got.near);
          n_errors++;
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [gcrf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gcrf_pkg::CFG_REF_LAT:  ref_lat_q = val[gcrf_pkg::LAT_W-1:0];
      gcrf_pkg::CFG_REF_LON:  ref_lon_q = val[gcrf_pkg::LON_W-1:0];
      gcrf_pkg::CFG_MAX_DIST: limit_q   = val[gcrf_pkg::DIST_W-1:0];
      default: ;
    endcase
  endtask

  // offer one point, hold it until the block takes it
  task automatic send_point(input point_row_t row);
    int goal;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    sent_rows_q = {sent_rows_q, row};
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, row.lon, row.lat, row.id};
    n_sent++;
    goal = n_sent;
    do @(negedge clk); while (n_accepted != goal);
  endtask

  // called at a falling edge right after the last accepted request
  task automatic drain_block();
    in_tvalid <= 1'b0;
    wait (pending_dist_q.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic point_row_t random_point();
    point_row_t r;
    int         k;
    r.id    = gcrf_pkg::ID_W'($urandom);
    r.typed = 1'b0;
    r.km16  = '0;
    r.near  = 1'b0;
    k = $urandom_range(99);
    if (k < 10) begin
      // raw bit patterns, out of range included
      r.lat = gcrf_pkg::LAT_W'($urandom);
      r.lon = gcrf_pkg::LON_W'($urandom);
    end else if (k < 45) begin
      // close to the reference point
      r.lat = gcrf_pkg::LAT_W'(ref_lat_q + $signed($urandom_range(400000)) - 200000);
      r.lon = gcrf_pkg::LON_W'(ref_lon_q + $signed($urandom_range(800000)) - 400000);
    end else begin
      r.lat = gcrf_pkg::LAT_W'($signed($urandom_range(11796480)) - 5898240);
      r.lon = gcrf_pkg::LON_W'($signed($urandom_range(23592960)) - 11796480);
    end
    return r;
  endfunction

  task automatic random_phase(input int n, input int s_pct, input int r_pct,
                              input bit hold_first, input bit pause_mid);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (hold_first) hold_cnt = HOLD_CYCLES;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_tvalid <= 1'b0;
        wait (pending_dist_q.size() == 0);
        @(negedge clk);
      end
      send_point(random_point());
    end
    drain_block();
  endtask

  // directed points: extremes, poles, antipode, wrapped bit patterns
  point_row_t directed_rows [] = '{
    '{16'h0000, 24'sd0, 25'sd0, 1'b1, 19'd0, 1'b1},
    '{16'hFFFF, 24'sd0, 25'sd0, 1'b1, 19'd0, 1'b1},
    '{16'h0001, 24'sd5898240, 25'sd0, 1'b0, 19'd0, 1'b0},
    '{16'h0002, -24'sd5898240, 25'sd0, 1'b0, 19'd0, 1'b0},
    '{16'h0003, 24'sd0, 25'sd11796480, 1'b0, 19'd0, 1'b0},
    '{16'h0004, 24'sd0, -25'sd11796480, 1'b0, 19'd0, 1'b0},
    '{16'h0005, 24'sd5898240, 25'sd11796480, 1'b0, 19'd0, 1'b0},
    '{16'h0006, -24'sd5898240, -25'sd11796480, 1'b0, 19'd0, 1'b0},
    '{16'h0007, 24'sd589824, 25'sd589824, 1'b0, 19'd0, 1'b0},
    '{16'h0008, 24'sd1, 25'sd1, 1'b0, 19'd0, 1'b0},
    '{16'h0009, 24'sd0, 25'sd587000, 1'b0, 19'd0, 1'b0},
    '{16'h000A, 24'sh7FFFFF, 25'sh0FFFFFF, 1'b0, 19'd0, 1'b0},
    '{16'h000B, 24'sh800000, 25'sh1000000, 1'b0, 19'd0, 1'b0},
    '{16'h5555, 24'sh555555, 25'sh0AAAAAA, 1'b0, 19'd0, 1'b0},
    '{16'hAAAA, 24'shAAAAAA, 25'sh1555555, 1'b0, 19'd0, 1'b0},
    '{16'h000C, -24'sd1, -25'sd1, 1'b0, 19'd0, 1'b0}
  };

  // main sequence
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_we        = 1'b0;
    cfg_index     = gcrf_pkg::CFG_REF_LAT;
    cfg_wdata     = '0;
    n_accepted    = 0;
    n_sent        = 0;
    n_errors      = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cnt      = 0;
    ref_lat_q     = '0;
    ref_lon_q     = '0;
    limit_q       = gcrf_pkg::MAX_DIST_RST;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings
    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (directed_rows[i]) send_point(directed_rows[i]);
    drain_block();

    // north pole reference, widest limit, junk above the register width
    write_reg(gcrf_pkg::CFG_REF_LAT, 25'h1000000 | 25'd5898240);
    write_reg(gcrf_pkg::CFG_REF_LON, -25'sd11796480);
    write_reg(gcrf_pkg::CFG_MAX_DIST, 25'h1F80000 | 25'd524287);
    write_reg(2'd3, 25'h1234567);
    random_phase(500, 34, 61, 1'b1, 1'b0);

    // south pole reference, zero limit
    write_reg(gcrf_pkg::CFG_REF_LAT, -25'sd5898240);
    write_reg(gcrf_pkg::CFG_REF_LON, 25'sd11796480);
    write_reg(gcrf_pkg::CFG_MAX_DIST, 25'd0);
    random_phase(500, 61, 34, 1'b0, 1'b1);

    // mid latitude reference, default limit, full rate
    write_reg(gcrf_pkg::CFG_REF_LAT, 25'sd3145728);
    write_reg(gcrf_pkg::CFG_REF_LON, -25'sd4718592);
    write_reg(gcrf_pkg::CFG_MAX_DIST, 25'd16000);
    random_phase(500, 0, 0, 1'b0, 1'b0);

    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
